// File: hdl/bitmap_slot_run_allocator_assert.svh
// assertion macros for the bitmap slot run allocator
// used by bitmap_slot_run_allocator.sv; expects aclk and aresetn in scope
`ifndef BITMAP_SLOT_RUN_ALLOCATOR_ASSERT_SVH
`define BITMAP_SLOT_RUN_ALLOCATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BSRA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bsra check failed");

// next-cycle implication, checked out of reset
`define BSRA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bsra check failed");

`endif

// File: hdl/bsra_pkg.sv
// shared types and constants for the bitmap slot run allocator
// no dependencies
`default_nettype none

package bsra_pkg;

    // field widths
    localparam int OP_W    = 2;
    localparam int START_W = 8;
    localparam int LEN_W   = 6;
    localparam int SLOT_W  = 9;
    localparam int LEN_CMP_W = 7;

    // bitmap word organization
    localparam int WORD_BITS  = 8;
    localparam int WORD_SHIFT = 3;

    // slots 0 and 1 hold the dot entries
    localparam int FIRST_NAMED_SLOT = 2;
    localparam logic [WORD_BITS-1:0] DOT_WORD = WORD_BITS'(3);

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_ACTIVE_SLOTS = 1'b0;
    localparam logic [SLOT_W-1:0] ACTIVE_SLOTS_RESET = SLOT_W'(256);

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_INIT    = 2'd2,
        OP_NONE    = 2'd3
    } bsra_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_DOTS_RD,
        ST_DOTS,
        ST_DONE
    } bsra_state_t;

endpackage

`default_nettype wire

// File: hdl/bitmap_slot_run_allocator.sv
// first-fit run allocator over a slot occupancy bitmap held in a word memory
// depends on bsra_pkg and bitmap_slot_run_allocator_assert.svh
// allocate scans words from 0 (not when length > MAX_RUN), rewrites each marked word;
//   release rewrites each touched word; init writes word 0; each op then checks dots;
//   one item at a time, next taken once result registered
// reset: synchronous active-low; bitmap rows marked invalid (read as free), limit 256
`default_nettype none

`include "bitmap_slot_run_allocator_assert.svh"

module bitmap_slot_run_allocator
    import bsra_pkg::*;
#(
    parameter int SLOT_CAPACITY = 256,
    parameter int MAX_RUN       = 32
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // request channel
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [15:0]             s_tdata,   // start_slot[7:0], run_length[13:8]
    input  wire logic [OP_W-1:0]         s_tuser,   // op[1:0]
    // result channel
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [15:0]                  m_tdata,   // found_slot[8:0], only_dots[9]
    output logic [0:0]                   m_tuser,   // no_room[0]
    // configuration port
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [CFG_ADDR_W-1:0]   paddr,
    input  wire logic [CFG_DATA_W-1:0]   pwdata,
    output logic [CFG_DATA_W-1:0]        prdata,
    output logic                         pready
);

    localparam int WORDS   = (SLOT_CAPACITY + WORD_BITS - 1) / WORD_BITS;
    localparam int AW      = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW      = (AW + WORD_SHIFT > SLOT_W + 1) ? AW + WORD_SHIFT : SLOT_W + 1;
    localparam int RW      = $clog2(MAX_RUN + 1);
    localparam int CAP_SAT = (SLOT_CAPACITY < 511) ? SLOT_CAPACITY : 511;
    localparam logic [SLOT_W-1:0]    CAP_LIM   = SLOT_W'(CAP_SAT);
    localparam logic [LEN_CMP_W-1:0] MAX_RUN_L = LEN_CMP_W'(MAX_RUN);
    localparam logic [RW-1:0]        RUN_SAT   = RW'(MAX_RUN);

    // request fields
    logic [START_W-1:0] in_start;
    logic [LEN_W-1:0]   in_len;
    bsra_op_t           in_op;

    assign in_start = s_tdata[START_W-1:0];
    assign in_len   = s_tdata[START_W+LEN_W-1:START_W];
    assign in_op    = bsra_op_t'(s_tuser);

    // configuration register
    logic [SLOT_W-1:0] active_slots_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ACTIVE_SLOTS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_slots_reg <= ACTIVE_SLOTS_RESET;
        end else if (cfg_wr) begin
            active_slots_reg <= pwdata[SLOT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ACTIVE_SLOTS) ?
                    {{(CFG_DATA_W-SLOT_W){1'b0}}, active_slots_reg} : '0;

    // bitmap memory and row valid bits
    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_ok_reg;
    logic [WORDS-1:0]     row_valid_reg, row_valid_next;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [WORD_BITS-1:0] word_eff;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        rd_ok_reg   <= row_valid_reg[rd_addr];
    end

    // a row never written since reset or init reads as all free
    assign word_eff = rd_ok_reg ? rd_data_reg : '0;

    // sequencer and working registers
    bsra_state_t        state_reg, state_next;
    bsra_op_t           op_reg, op_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [SLOT_W-1:0]  limit_reg, limit_next;
    logic [AW-1:0]      wp_reg, wp_next;
    logic [RW-1:0]      run_reg, run_next;
    logic [PW-1:0]      run_start_reg, run_start_next;
    logic [PW-1:0]      lo_reg, lo_next;
    logic [PW-1:0]      hi_reg, hi_next;
    logic [SLOT_W-1:0]  found_reg, found_next;
    logic               none_reg, none_next;
    logic               dots_reg, dots_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [SLOT_W-1:0]  m_found_reg, m_found_next;
    logic               m_none_reg, m_none_next;
    logic               m_dots_reg, m_dots_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            row_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            row_valid_reg <= row_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        len_reg       <= len_next;
        limit_reg     <= limit_next;
        wp_reg        <= wp_next;
        run_reg       <= run_next;
        run_start_reg <= run_start_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        found_reg     <= found_next;
        none_reg      <= none_next;
        dots_reg      <= dots_next;
        m_found_reg   <= m_found_next;
        m_none_reg    <= m_none_next;
        m_dots_reg    <= m_dots_next;
    end

    // word geometry for the word in rd_data_reg
    logic [PW-1:0] word_base, next_base, limit_ext;

    assign word_base = PW'({wp_reg, {WORD_SHIFT{1'b0}}});
    assign next_base = word_base + PW'(WORD_BITS);
    assign limit_ext = PW'(limit_reg);

    // run search over one word, eight dependent steps
    logic [RW-1:0] scan_run;
    logic [PW-1:0] scan_rs;
    logic          scan_hit;
    logic [PW-1:0] scan_at;

    always_comb begin
        logic [PW-1:0] pos_v;
        scan_run = run_reg;
        scan_rs  = run_start_reg;
        scan_hit = 1'b0;
        scan_at  = '0;
        for (int k = 0; k < WORD_BITS; k++) begin
            pos_v = word_base + PW'(k);
            if ((pos_v < limit_ext) && !scan_hit) begin
                if (word_eff[k]) begin
                    scan_run = '0;
                    scan_rs  = pos_v + PW'(1);
                end else begin
                    if (scan_run != RUN_SAT) begin
                        scan_run = scan_run + RW'(1);
                    end
                    if (LEN_CMP_W'(scan_run) >= LEN_CMP_W'(len_reg)) begin
                        scan_hit = 1'b1;
                        scan_at  = scan_rs;
                    end
                end
            end
        end
    end

    // set or clear mask over [lo, hi) for the current word
    logic [WORD_BITS-1:0] rmw_mask, rmw_word;

    always_comb begin
        logic [PW-1:0] pos_v;
        for (int k = 0; k < WORD_BITS; k++) begin
            pos_v = word_base + PW'(k);
            rmw_mask[k] = (pos_v >= lo_reg) && (pos_v < hi_reg);
        end
        rmw_word = (op_reg == OP_ALLOC) ? (word_eff | rmw_mask) : (word_eff & ~rmw_mask);
    end

    // any used slot in [2, limit) within the current word
    logic dots_used;

    always_comb begin
        logic [PW-1:0] pos_v;
        dots_used = 1'b0;
        for (int k = 0; k < WORD_BITS; k++) begin
            pos_v = word_base + PW'(k);
            if ((pos_v >= PW'(FIRST_NAMED_SLOT)) && (pos_v < limit_ext) && word_eff[k]) begin
                dots_used = 1'b1;
            end
        end
    end

    // request-side helpers
    logic [SLOT_W-1:0] in_limit;
    logic [PW-1:0]     rel_lo, rel_end, rel_hi;

    assign in_limit = (active_slots_reg < CAP_LIM) ? active_slots_reg : CAP_LIM;
    assign rel_lo   = PW'(in_start);
    assign rel_end  = PW'(in_start) + PW'(in_len);
    assign rel_hi   = (rel_end < PW'(in_limit)) ? rel_end : PW'(in_limit);

    // next state and datapath control
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        len_next       = len_reg;
        limit_next     = limit_reg;
        wp_next        = wp_reg;
        run_next       = run_reg;
        run_start_next = run_start_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        found_next     = found_reg;
        none_next      = none_reg;
        dots_next      = dots_reg;
        row_valid_next = row_valid_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_found_next   = m_found_reg;
        m_none_next    = m_none_reg;
        m_dots_next    = m_dots_reg;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        s_tready       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next        = in_op;
                    len_next       = in_len;
                    limit_next     = in_limit;
                    wp_next        = '0;
                    run_next       = '0;
                    run_start_next = '0;
                    found_next     = '0;
                    none_next      = 1'b0;
                    dots_next      = 1'b1;
                    case (in_op)
                        OP_ALLOC: begin
                            if ({1'b0, in_len} > MAX_RUN_L) begin
                                found_next = in_limit;
                                none_next  = 1'b1;
                                state_next = ST_DOTS_RD;
                            end else begin
                                // word 0 is read this cycle
                                state_next = ST_SCAN;
                            end
                        end
                        OP_RELEASE: begin
                            lo_next = rel_lo;
                            hi_next = rel_hi;
                            wp_next = rel_lo[AW+WORD_SHIFT-1:WORD_SHIFT];
                            state_next = (rel_lo < rel_hi) ? ST_RMW_RD : ST_DOTS_RD;
                        end
                        OP_INIT: begin
                            row_valid_next = WORDS'(1);
                            wr_en          = 1'b1;
                            wr_addr        = '0;
                            wr_data        = DOT_WORD;
                            state_next     = ST_DOTS_RD;
                        end
                        default: begin
                            state_next = ST_DOTS_RD;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                rd_addr = wp_reg + AW'(1);
                if (scan_hit) begin
                    found_next = scan_at[SLOT_W-1:0];
                    lo_next    = scan_at;
                    hi_next    = scan_at + PW'(len_reg);
                    wp_next    = scan_at[AW+WORD_SHIFT-1:WORD_SHIFT];
                    state_next = (len_reg == '0) ? ST_DOTS_RD : ST_RMW_RD;
                end else if (next_base >= limit_ext) begin
                    found_next = limit_reg;
                    none_next  = 1'b1;
                    state_next = ST_DOTS_RD;
                end else begin
                    wp_next        = wp_reg + AW'(1);
                    run_next       = scan_run;
                    run_start_next = scan_rs;
                end
            end

            ST_RMW_RD: begin
                rd_addr    = wp_reg;
                state_next = ST_RMW_WR;
            end

            ST_RMW_WR: begin
                wr_en   = 1'b1;
                wr_addr = wp_reg;
                wr_data = rmw_word;
                row_valid_next[wp_reg] = 1'b1;
                if (next_base >= hi_reg) begin
                    state_next = ST_DOTS_RD;
                end else begin
                    wp_next    = wp_reg + AW'(1);
                    state_next = ST_RMW_RD;
                end
            end

            ST_DOTS_RD: begin
                rd_addr    = '0;
                wp_next    = '0;
                state_next = ST_DOTS;
            end

            ST_DOTS: begin
                rd_addr   = wp_reg + AW'(1);
                dots_next = dots_reg && !dots_used;
                if (next_base >= limit_ext) begin
                    state_next = ST_DONE;
                end else begin
                    wp_next = wp_reg + AW'(1);
                end
            end

            ST_DONE: begin
                // hand the result over once the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_found_next = found_reg;
                    m_none_next  = none_reg;
                    m_dots_next  = dots_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result channel
    logic out_stall;

    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(16-SLOT_W-1){1'b0}}, m_dots_reg, m_found_reg};
    assign m_tuser   = m_none_reg;
    assign out_stall = m_valid_reg && !m_tready;

    // checks
    `BSRA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `BSRA_ASSERT_NOW(a_rmw_word_in_range, state_reg == ST_RMW_WR, word_base < hi_reg)
    `BSRA_ASSERT_NEXT(a_done_holds, state_reg == ST_DONE && out_stall, state_reg == ST_DONE)

endmodule

`default_nettype wire
